### src/line_follow_motor_fsm_core_defines.svh
// ----------------------------------------------------------------------------
// Line follower motor controller: assertion macros
// Shared property forms for the checker, clocked on aclk, muted in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_MOTOR_FSM_CORE_DEFINES_SVH
`define LINE_FOLLOW_MOTOR_FSM_CORE_DEFINES_SVH

// same-cycle implication
`define LFM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line follower check failed");

// next-cycle implication
`define LFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line follower check failed");

`endif

### src/lfm_pkg.sv
// ----------------------------------------------------------------------------
// Line follower motor controller package
// Widths, codes and the fixed state table of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfm_pkg;

    localparam int DUTY_W     = 14;
    localparam int SENSOR_W   = 3;
    localparam int MODE_W     = 4;
    localparam int DWELL_W    = 10;
    localparam int DRIVE_W    = 2;
    localparam int CFG_ADDR_W = 2;

    typedef logic [DUTY_W-1:0]   duty_t;
    typedef logic [SENSOR_W-1:0] sensor_t;
    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [DWELL_W-1:0]  dwell_t;
    typedef logic [DRIVE_W-1:0]  drive_t;

    localparam duty_t DUTY_MAX         = 14'd14998;
    localparam duty_t DUTY_FULL_RST    = 14'd4999;
    localparam duty_t DUTY_HIGH_RST    = 14'd4333;
    localparam duty_t DUTY_MEDIUM_RST  = 14'd3333;
    localparam duty_t DUTY_LOW_RST     = 14'd1666;

    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_FULL   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_HIGH   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_MEDIUM = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY_LOW    = 2'd3;

    localparam mode_t MODE_ON_LINE = 4'd0;
    localparam mode_t MODE_STOP    = 4'd11;
    localparam mode_t MODE_LAST    = 4'd14;

    localparam dwell_t DWELL_ON_LINE = 10'd40;
    localparam dwell_t DWELL_STOP    = 10'd1000;

    typedef enum logic [2:0] {
        LV_ZERO,
        LV_FULL,
        LV_HIGH,
        LV_MED,
        LV_LOW,
        LV_NMED
    } level_t;

    typedef struct packed {
        duty_t full;
        duty_t high;
        duty_t med;
        duty_t low;
    } cfg_t;

    typedef struct packed {
        logic   entered;
        mode_t  mode;
        duty_t  right_duty;
        duty_t  left_duty;
        drive_t drive_mode;
    } result_t;

    function automatic mode_t mode_next(mode_t m, sensor_t s);
        mode_t nxt;
        case (s)
            3'd1:    nxt = 4'd3;
            3'd2:    nxt = 4'd2;
            3'd3:    nxt = 4'd1;
            3'd4:    nxt = 4'd0;
            3'd5:    nxt = 4'd4;
            3'd6:    nxt = 4'd5;
            3'd7:    nxt = 4'd6;
            default: nxt = 4'd0;
        endcase
        case (m)
            4'd0:              if (s == 3'd0) nxt = 4'd9;
            4'd1, 4'd2, 4'd3:  if (s == 3'd0) nxt = 4'd7;
            4'd4, 4'd5, 4'd6:  if (s == 3'd0) nxt = 4'd8;
            4'd7:              if (s == 3'd0) nxt = 4'd13;
            4'd8:              if (s == 3'd0) nxt = 4'd14;
            4'd9:              if (s == 3'd0) nxt = 4'd10;
            4'd10:             if (s == 3'd0) nxt = 4'd12;
            4'd12:             if (s == 3'd0) nxt = MODE_STOP;
            4'd13, 4'd14:      if (s == 3'd0) nxt = 4'd9;
            default:           nxt = MODE_STOP;
        endcase
        return nxt;
    endfunction

    function automatic dwell_t mode_dwell(mode_t m);
        case (m)
            4'd0:                    return DWELL_ON_LINE;
            4'd1, 4'd4:              return 10'd25;
            4'd2, 4'd3, 4'd5, 4'd6:  return 10'd15;
            4'd7, 4'd8, 4'd13, 4'd14: return 10'd400;
            4'd9, 4'd10:             return 10'd700;
            4'd12:                   return 10'd650;
            default:                 return DWELL_STOP;
        endcase
    endfunction

    function automatic level_t mode_left(mode_t m);
        case (m)
            4'd0, 4'd1, 4'd2, 4'd3: return LV_FULL;
            4'd4:                   return LV_HIGH;
            4'd5, 4'd7, 4'd9, 4'd12, 4'd14: return LV_MED;
            4'd6:                   return LV_LOW;
            4'd8, 4'd10, 4'd13:     return LV_NMED;
            default:                return LV_ZERO;
        endcase
    endfunction

    function automatic level_t mode_right(mode_t m);
        case (m)
            4'd0, 4'd4, 4'd5, 4'd6: return LV_FULL;
            4'd1:                   return LV_HIGH;
            4'd2, 4'd8, 4'd10, 4'd12, 4'd13: return LV_MED;
            4'd3:                   return LV_LOW;
            4'd7, 4'd9, 4'd14:      return LV_NMED;
            default:                return LV_ZERO;
        endcase
    endfunction

    function automatic duty_t sat_duty(duty_t v);
        return (v > DUTY_MAX) ? DUTY_MAX : v;
    endfunction

    function automatic duty_t level_mag(level_t lv, cfg_t cfg);
        case (lv)
            LV_FULL:         return sat_duty(cfg.full);
            LV_HIGH:         return sat_duty(cfg.high);
            LV_MED, LV_NMED: return sat_duty(cfg.med);
            LV_LOW:          return sat_duty(cfg.low);
            default:         return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/lfm_step.sv
// ----------------------------------------------------------------------------
// Line follower step logic
// Next state, dwell count and motor command for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module lfm_step
    import lfm_pkg::*;
(
    input  wire mode_t   mode_cur,
    input  wire dwell_t  dwell_cur,
    input  wire sensor_t line_sensor,
    input  wire logic    collision,
    input  wire cfg_t    cfg,
    output mode_t        mode_nxt,
    output dwell_t       dwell_nxt,
    output result_t      result
);

    mode_t  mode_safe;
    logic   entered;
    level_t lv_left;
    level_t lv_right;

    assign mode_safe = (mode_cur > MODE_LAST) ? MODE_STOP : mode_cur;

    always_comb begin
        entered = 1'b1;
        if (collision) begin
            mode_nxt  = MODE_STOP;
            dwell_nxt = DWELL_STOP;
        end else if (dwell_cur <= 10'd1) begin
            mode_nxt  = mode_next(mode_safe, line_sensor);
            dwell_nxt = mode_dwell(mode_nxt);
        end else begin
            mode_nxt  = mode_safe;
            dwell_nxt = dwell_cur - 10'd1;
            entered   = 1'b0;
        end
    end

    assign lv_left  = mode_left(mode_nxt);
    assign lv_right = mode_right(mode_nxt);

    assign result.entered    = entered;
    assign result.mode       = mode_nxt;
    assign result.left_duty  = level_mag(lv_left, cfg);
    assign result.right_duty = level_mag(lv_right, cfg);
    assign result.drive_mode = {lv_right == LV_NMED, lv_left == LV_NMED};

endmodule

`default_nettype wire

### src/line_follow_motor_fsm_core.sv
// ----------------------------------------------------------------------------
// Line follower motor controller
// The result of an accepted tick is registered in the result register.
// Throughput: one tick per cycle while the output is not stalled; the state
// table lookup and dwell decrement sit between state and result registers.
// Reset: state 0 (on line) with dwell 40, duty registers at defaults,
// result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_motor_fsm_core
    import lfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DUTY_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // line_sensor[2:0], collision[3]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata    // drive_mode[1:0], left_duty[15:2],
                                                  // right_duty[29:16], current_mode[33:30],
                                                  // entered[34]
);

    cfg_t    cfg_reg;
    mode_t   mode_reg;
    dwell_t  dwell_reg;
    logic    out_valid_reg;
    result_t out_reg;

    mode_t   mode_next;
    dwell_t  dwell_next;
    result_t result_next;
    logic    s_xfer;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    lfm_step u_step (
        .mode_cur    (mode_reg),
        .dwell_cur   (dwell_reg),
        .line_sensor (s_tdata[2:0]),
        .collision   (s_tdata[3]),
        .cfg         (cfg_reg),
        .mode_nxt    (mode_next),
        .dwell_nxt   (dwell_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full <= DUTY_FULL_RST;
            cfg_reg.high <= DUTY_HIGH_RST;
            cfg_reg.med  <= DUTY_MEDIUM_RST;
            cfg_reg.low  <= DUTY_LOW_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DUTY_FULL:   cfg_reg.full <= cfg_wdata;
                REG_DUTY_HIGH:   cfg_reg.high <= cfg_wdata;
                REG_DUTY_MEDIUM: cfg_reg.med  <= cfg_wdata;
                REG_DUTY_LOW:    cfg_reg.low  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_ON_LINE;
            dwell_reg     <= DWELL_ON_LINE;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                mode_reg      <= mode_next;
                dwell_reg     <= dwell_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

`default_nettype wire

### src/lfm_checker.sv
// ----------------------------------------------------------------------------
// Line follower checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_follow_motor_fsm_core_defines.svh"

module lfm_checker
    import lfm_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [7:0]            s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [39:0]           m_tdata
);

    `LFM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LFM_ASSERT_NEXT(a_in_to_out, s_tvalid && s_tready, m_tvalid)
    `LFM_ASSERT_NEXT(a_collision_stop, s_tvalid && s_tready && s_tdata[3],
        m_tdata[33:30] == MODE_STOP && m_tdata[34] && m_tdata[29:2] == 28'd0)
    `LFM_ASSERT_NOW(a_mode_range, m_tvalid,
        m_tdata[33:30] != 4'd15 && m_tdata[1:0] != 2'd3)

endmodule

bind line_follow_motor_fsm_core lfm_checker u_lfm_checker (.*);

`default_nettype wire
